// ===== hw/rtl/life_automaton_generation_core_macros.svh =====
// ----------------------------------------------------------------------------
// Life generation core assertion macros
// Clocked property helpers for the asserting top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_GENERATION_CORE_MACROS_SVH
`define LIFE_AUTOMATON_GENERATION_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define LIFEGEN_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LIFEGEN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lifegen_pkg.sv =====
// ----------------------------------------------------------------------------
// Life generation package
// Sizes, codes and the request record shared by the life generation core.
// ----------------------------------------------------------------------------
`default_nettype none

package lifegen_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 64;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int HC_W   = $clog2(MAX_HEIGHT + 1);
    localparam int WC_W   = $clog2(MAX_WIDTH + 1);
    localparam int CNT_W  = $clog2(MAX_HEIGHT * MAX_WIDTH + MAX_WIDTH + 2);
    localparam int STEP_W = $clog2(CNT_W + 1);

    // configuration register fields
    localparam int HCFG_W = 7;
    localparam int WCFG_W = 8;
    localparam int CFG_W  = 8;

    localparam logic [HCFG_W-1:0] GRID_HEIGHT_RST = 7'd30;
    localparam logic [WCFG_W-1:0] GRID_WIDTH_RST  = 8'd120;
    localparam int CELLS_RST = 30 * 120;
    localparam int TOTAL_RST = CELLS_RST + 120 + 1;

    // stream packing
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = 1 + ROW_W + COL_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    // B3/S23 rule
    localparam int SURVIVE_LO = 2;
    localparam int SURVIVE_HI = 3;
    localparam int BIRTH_CNT  = 3;

    // request queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    typedef enum logic [0:0] {
        CFG_GRID_HEIGHT = 1'b0,
        CFG_GRID_WIDTH  = 1'b1
    } cfg_index_t;

    localparam logic CMD_CELL  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // one classified request
    typedef struct packed {
        logic             new_bit;   // new cell bit entering the window
        logic [COL_W-1:0] col;       // line store column
        logic             has_res;   // request yields a result
        logic             last;      // final result of the frame
        logic             ok_left;
        logic             ok_right;
        logic             ok_top;
        logic             ok_bottom;
        logic [ROW_W-1:0] row;       // result row
        logic [COL_W-1:0] res_col;   // result column
    } item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lifegen_ram.sv =====
// ----------------------------------------------------------------------------
// Life generation RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lifegen_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lifegen_front.sv =====
// ----------------------------------------------------------------------------
// Life generation front end
// Holds the size registers, tracks the frame position and classifies
// each request into a cell or flush with its result coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module lifegen_front
    import lifegen_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [0:0]       cfg_addr,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    input  wire logic             in_valid,
    input  wire logic             in_cmd,
    input  wire logic             in_cell,
    input  wire logic             q_full,
    output logic                  in_ready,
    output logic                  push,
    output item_t                 push_item
);

    logic [HCFG_W-1:0] hgt_reg;
    logic [WCFG_W-1:0] wid_reg;
    logic [HC_W-1:0]   hc;
    logic [WC_W-1:0]   wc;
    logic [CNT_W-1:0]  cells_reg;
    logic [CNT_W-1:0]  total_reg;

    logic [CNT_W-1:0]  seen_reg,  seen_next;
    logic [COL_W-1:0]  col_reg,   col_next;
    logic [CNT_W-1:0]  orow_reg,  orow_next;
    logic [COL_W-1:0]  ocol_reg,  ocol_next;

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [COL_W-1:0]  rem_reg;
    logic [COL_W:0]    rem_shift;
    logic [COL_W-1:0]  rem_step;

    logic              restart;
    logic [CNT_W-1:0]  n;
    logic [COL_W-1:0]  colx;
    logic [CNT_W-1:0]  orow;
    logic [COL_W-1:0]  ocol;
    logic [COL_W:0]    col_inc;
    logic [COL_W:0]    ocol_inc;
    logic              is_last;
    logic              has_res;

    // clamp sizes to 1..MAX
    always_comb
    begin
        if (hgt_reg == '0)
            hc = HC_W'(1);
        else if (int'(hgt_reg) > MAX_HEIGHT)
            hc = HC_W'(MAX_HEIGHT);
        else
            hc = HC_W'(hgt_reg);
        if (wid_reg == '0)
            wc = WC_W'(1);
        else if (int'(wid_reg) > MAX_WIDTH)
            wc = WC_W'(MAX_WIDTH);
        else
            wc = WC_W'(wid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hgt_reg   <= GRID_HEIGHT_RST;
            wid_reg   <= GRID_WIDTH_RST;
            cells_reg <= CNT_W'(CELLS_RST);
            total_reg <= CNT_W'(TOTAL_RST);
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_addr))
                    CFG_GRID_HEIGHT: hgt_reg <= cfg_wdata[HCFG_W-1:0];
                    CFG_GRID_WIDTH:  wid_reg <= cfg_wdata[WCFG_W-1:0];
                    default: ;
                endcase
            end
            cells_reg <= CNT_W'(hc) * CNT_W'(wc);
            total_reg <= cells_reg + CNT_W'(wc) + CNT_W'(1);
        end
    end

    // bit-serial remainder: column = position mod width after a size change
    assign rem_shift = {rem_reg, div_reg[CNT_W-1]};
    assign rem_step  = (rem_shift >= (COL_W+1)'(wc)) ? COL_W'(rem_shift - (COL_W+1)'(wc))
                                                     : COL_W'(rem_shift);

    assign in_ready = !busy_reg && !q_full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        restart = seen_reg >= total_reg;
        n       = restart ? '0 : seen_reg;
        colx    = restart ? '0 : col_reg;
        orow    = restart ? '0 : orow_reg;
        ocol    = restart ? '0 : ocol_reg;
        is_last = (n + CNT_W'(1)) == total_reg;
        has_res = n >= (CNT_W'(wc) + CNT_W'(1));

        push_item.new_bit   = (n < cells_reg) && (in_cmd == CMD_CELL) && in_cell;
        push_item.col       = colx;
        push_item.has_res   = has_res;
        push_item.last      = is_last;
        push_item.ok_left   = ocol != '0;
        push_item.ok_right  = (COL_W+1)'(ocol) != ((COL_W+1)'(wc) - (COL_W+1)'(1));
        push_item.ok_top    = orow != '0;
        push_item.ok_bottom = orow != (CNT_W'(hc) - CNT_W'(1));
        push_item.row       = orow[ROW_W-1:0];
        push_item.res_col   = ocol;

        col_inc  = (COL_W+1)'(colx) + (COL_W+1)'(1);
        ocol_inc = (COL_W+1)'(ocol) + (COL_W+1)'(1);

        if (is_last)
        begin
            seen_next = '0;
            col_next  = '0;
            orow_next = '0;
            ocol_next = '0;
        end
        else
        begin
            seen_next = n + CNT_W'(1);
            col_next  = (col_inc == (COL_W+1)'(wc)) ? '0 : col_inc[COL_W-1:0];
            orow_next = orow;
            ocol_next = ocol;
            if (has_res)
            begin
                if (ocol_inc >= (COL_W+1)'(wc))
                begin
                    ocol_next = '0;
                    orow_next = orow + CNT_W'(1);
                end
                else
                begin
                    ocol_next = ocol_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            col_reg  <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
            busy_reg <= 1'b0;
            step_reg <= '0;
            div_reg  <= '0;
            rem_reg  <= '0;
        end
        else if (cfg_we)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(CNT_W);
            div_reg  <= seen_reg;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_step;
            div_reg  <= div_reg << 1;
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                col_reg  <= rem_step;
            end
        end
        else if (push)
        begin
            seen_reg <= seen_next;
            col_reg  <= col_next;
            orow_reg <= orow_next;
            ocol_reg <= ocol_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lifegen_fifo.sv =====
// ----------------------------------------------------------------------------
// Life generation request queue
// Short show-ahead queue between the front end and the window back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lifegen_fifo
    import lifegen_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  item_t     push_item,
    input  wire logic pop,
    output item_t     head,
    output logic      full,
    output logic      empty
);

    item_t            mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = count_reg == (PTR_W+1)'(FIFO_DEPTH);
    assign empty = count_reg == '0;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (PTR_W+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PTR_W+1)'(1);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lifegen_back.sv =====
// ----------------------------------------------------------------------------
// Life generation back end
// Line store read-modify-write, 3x3 window, neighbor count and result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module lifegen_back
    import lifegen_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  item_t                 head,
    input  wire logic             q_empty,
    output logic                  pop,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic                  out_alive,
    output logic [ROW_W-1:0]      out_row,
    output logic [COL_W-1:0]      out_col,
    output logic                  out_last
);

    item_t          b_item_reg;
    logic           b_valid_reg;
    logic           b_fire;

    logic [1:0]     ram_rdata;
    logic [1:0]     ram_wdata;
    logic [MAX_WIDTH-1:0] vld_reg;
    logic           rd_vld_reg;
    logic           fwd_reg;
    logic [1:0]     fwd_data_reg;
    logic [1:0]     rd;

    logic [8:0]     win_reg;
    logic [8:0]     win_new;
    logic [3:0]     cnt;
    logic           use_bit;
    logic           alive;

    logic           out_valid_reg;
    logic           out_alive_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic           out_last_reg;

    assign b_fire = b_valid_reg && (!b_item_reg.has_res || !out_valid_reg || out_ready);
    assign pop    = !q_empty && (!b_valid_reg || b_fire);

    // stored bit 0 = two rows up, bit 1 = one row up
    assign rd        = fwd_reg ? fwd_data_reg : (rd_vld_reg ? ram_rdata : 2'b00);
    assign ram_wdata = {b_item_reg.new_bit, rd[1]};

    lifegen_ram #(
        .WIDTH(2),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (b_fire),
        .waddr (b_item_reg.col),
        .wdata (ram_wdata),
        .re    (pop),
        .raddr (head.col),
        .rdata (ram_rdata)
    );

    // window bit 3*col+row, col 0 oldest, row 0 top
    assign win_new = {b_item_reg.new_bit, rd[1], rd[0], win_reg[8:3]};

    always_comb
    begin
        cnt     = '0;
        use_bit = 1'b0;
        for (int c = 0; c < 3; c++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                use_bit = (c != 0 || b_item_reg.ok_left)
                       && (c != 2 || b_item_reg.ok_right)
                       && (r != 0 || b_item_reg.ok_top)
                       && (r != 2 || b_item_reg.ok_bottom)
                       && !(c == 1 && r == 1);
                if (use_bit)
                    cnt = cnt + 4'(win_new[3*c+r]);
            end
        end
        if (win_new[4])
            alive = (cnt == 4'(SURVIVE_LO)) || (cnt == 4'(SURVIVE_HI));
        else
            alive = cnt == 4'(BIRTH_CNT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            fwd_reg       <= 1'b0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                b_valid_reg <= 1'b1;
            else if (b_fire)
                b_valid_reg <= 1'b0;

            if (pop)
            begin
                rd_vld_reg <= vld_reg[head.col];
                fwd_reg    <= b_fire && (b_item_reg.col == head.col);
            end

            if (b_fire)
            begin
                vld_reg[b_item_reg.col] <= 1'b1;
                win_reg                 <= win_new;
            end

            if (b_fire && b_item_reg.has_res)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_item_reg   <= head;
            fwd_data_reg <= ram_wdata;
        end
        if (b_fire && b_item_reg.has_res)
        begin
            out_alive_reg <= alive;
            out_row_reg   <= b_item_reg.row;
            out_col_reg   <= b_item_reg.res_col;
            out_last_reg  <= b_item_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_alive = out_alive_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/life_automaton_generation_core.sv =====
// ----------------------------------------------------------------------------
// Life automaton generation core
// One B3/S23 generation over a streamed, dead-bordered grid.
// ----------------------------------------------------------------------------
// Takes one cell per clock in raster order and returns one result per clock
// once the pipe is full and no resync or output stall holds it; the result
// for cell k leaves after cell k+W+1 is accepted, with m_axis_tvalid rising
// once that request has passed the queue, the pop with line store read, and
// the window count into the output register. After each frame send W+1
// flush requests. The rate is set by the line store read-modify-write, one
// column per cycle. After any configuration write the input stalls while a
// bit-serial remainder unit recomputes the column from the frame position.
`default_nettype none

`include "life_automaton_generation_core_macros.svh"

module life_automaton_generation_core
    import lifegen_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration
    input  wire logic                   cfg_we,
    input  wire logic [0:0]             cfg_addr,
    input  wire logic [CFG_W-1:0]       cfg_wdata,
    // cell stream in
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [0] cell_alive
    input  wire logic                   s_axis_tuser,   // [0] command
    // result stream out
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,   // [0] next_alive, row_index, col_index
    output logic                        m_axis_tlast    // frame_last
);

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    item_t            q_in;
    item_t            q_head;
    logic             res_alive;
    logic [ROW_W-1:0] res_row;
    logic [COL_W-1:0] res_col;

    lifegen_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_cmd    (s_axis_tuser),
        .in_cell   (s_axis_tdata[0]),
        .q_full    (q_full),
        .in_ready  (s_axis_tready),
        .push      (q_push),
        .push_item (q_in)
    );

    lifegen_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    lifegen_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .q_empty   (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_alive (res_alive),
        .out_row   (res_row),
        .out_col   (res_col),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, res_col, res_row, res_alive};

    `LIFEGEN_ASSERT_SAME(a_queue_no_overflow, q_push, !q_full, "request queue overflow")
    `LIFEGEN_ASSERT_SAME(a_queue_no_underflow, q_pop, !q_empty, "request queue underflow")
    `LIFEGEN_ASSERT_NEXT(a_cfg_stalls_input, cfg_we, !s_axis_tready, "input open during resync")

endmodule

`default_nettype wire

// ===== sim/life_automaton_generation_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life automaton generation core testbench
// Streams dead-bordered grids through the core under random stalls on both
// sides and checks every next-generation cell against a B3/S23 predictor.
// ----------------------------------------------------------------------------
module life_automaton_generation_core_test;
    import lifegen_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 24;
    localparam int TARGET_ITEMS   = 600;

    typedef struct {
        logic cmd;
        logic alive;
    } cell_req_t;

    typedef struct packed {
        logic             next_alive;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } gen_cell_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_we        = 1'b0;
    logic [0:0]             cfg_addr      = CFG_GRID_HEIGHT;
    logic [CFG_W-1:0]       cfg_wdata     = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = CMD_CELL;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    // predictor state
    logic [HCFG_W-1:0] grid_h_reg;
    logic [WCFG_W-1:0] grid_w_reg;
    logic              line_top [MAX_WIDTH];
    logic              line_mid [MAX_WIDTH];
    logic [8:0]        window;      // bit 3*col+row, col 0 oldest, row 0 top
    int                frame_pos;
    int                res_row;
    int                res_col;

    cell_req_t pending_cells[$];
    gen_cell_t next_gen_q[$];
    cell_req_t next_req;
    gen_cell_t want_cell;

    bit presenting   = 1'b0;
    bit in_taken     = 1'b0;
    bit res_taken    = 1'b0;
    bit in_stall_on  = 1'b1;
    bit out_stall_on = 1'b1;
    int in_gap       = 0;
    int out_gap      = 0;
    int gen_pos      = 0;
    int items_queued = 0;
    int err_count    = 0;
    int idle_cycles  = 0;

    life_automaton_generation_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [0] cell_alive
        .s_axis_tuser  (s_axis_tuser),    // [0] command
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [0] next_alive, [6:1] row_index, [13:7] col_index
        .m_axis_tlast  (m_axis_tlast)     // frame_last
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int frame_items();
        int h;
        int w;
        h = clamp_dim(grid_h_reg, MAX_HEIGHT);
        w = clamp_dim(grid_w_reg, MAX_WIDTH);
        return h * w + w + 1;
    endfunction

    // one B3/S23 step for the accepted request
    function automatic void predict_generation(logic cmd, logic alive);
        int        h;
        int        w;
        int        cells;
        int        total;
        int        n;
        int        col;
        int        cnt;
        int        c;
        int        r;
        logic      v;
        logic      okl;
        logic      okr;
        logic      okt;
        logic      okb;
        gen_cell_t res;
        h     = clamp_dim(grid_h_reg, MAX_HEIGHT);
        w     = clamp_dim(grid_w_reg, MAX_WIDTH);
        cells = h * w;
        total = cells + w + 1;
        if (frame_pos >= total)
        begin
            frame_pos = 0;
            res_row   = 0;
            res_col   = 0;
        end
        n = frame_pos;
        // position decides the kind: flush in cell region reads as dead
        v   = (n < cells && cmd == CMD_CELL) ? alive : 1'b0;
        col = n % w;
        window = {v, line_mid[col], line_top[col], window[8:3]};
        line_top[col] = line_mid[col];
        line_mid[col] = v;
        frame_pos = n + 1;
        if (n < w + 1)
            return;

        okl = (res_col != 0);
        okr = (res_col != w - 1);
        okt = (res_row != 0);
        okb = (res_row != h - 1);
        cnt = 0;
        for (c = 0; c < 3; c++)
        begin
            for (r = 0; r < 3; r++)
            begin
                if (!(c == 1 && r == 1) && (c != 0 || okl) && (c != 2 || okr)
                    && (r != 0 || okt) && (r != 2 || okb))
                    cnt += window[3 * c + r];
            end
        end
        res.next_alive = window[4] ? (cnt == SURVIVE_LO || cnt == SURVIVE_HI)
                                   : (cnt == BIRTH_CNT);
        res.row  = res_row[ROW_W-1:0];
        res.col  = res_col[COL_W-1:0];
        res.last = (n + 1 == total);
        next_gen_q.push_back(res);

        if (n + 1 == total)
        begin
            frame_pos = 0;
            res_row   = 0;
            res_col   = 0;
        end
        else
        begin
            res_col++;
            if (res_col >= w)
            begin
                res_col = 0;
                res_row++;
            end
        end
    endfunction

    function automatic void push_req(logic cmd, logic alive);
        cell_req_t req;
        req.cmd   = cmd;
        req.alive = alive;
        pending_cells.push_back(req);
        items_queued++;
    endfunction

    // raster requests from the current frame position, with optional wrong commands
    function automatic void queue_cells(int count, int noise_pct, int density);
        int   i;
        int   total;
        int   cells;
        logic cmd;
        total = frame_items();
        cells = clamp_dim(grid_h_reg, MAX_HEIGHT) * clamp_dim(grid_w_reg, MAX_WIDTH);
        for (i = 0; i < count; i++)
        begin
            if (gen_pos >= total)
                gen_pos = 0;
            cmd = (gen_pos < cells) ? CMD_CELL : CMD_FLUSH;
            if ($urandom_range(99) < noise_pct)
                cmd = ~cmd;
            push_req(cmd, $urandom_range(99) < density);
            gen_pos = (gen_pos + 1) % total;
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    task automatic write_grid_reg(cfg_index_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_GRID_HEIGHT)
            grid_h_reg = val[HCFG_W-1:0];
        else
            grid_w_reg = val;
    endtask

    // all requests sent, all results back, pipe given time to empty
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cells.size() != 0 || presenting || next_gen_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // request driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_taken)
                presenting = 1'b0;
            if (!presenting)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if (pending_cells.size() != 0)
                begin
                    next_req = pending_cells.pop_front();
                    s_axis_tuser <= next_req.cmd;
                    s_axis_tdata <= {{(IN_TDATA_W-1){1'b0}}, next_req.alive};
                    presenting = 1'b1;
                    in_gap = in_stall_on ? $urandom_range(0, 15) : 0;
                end
            end
            s_axis_tvalid <= presenting;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_generation(s_axis_tuser, s_axis_tdata[0]);
            in_taken <= 1'b1;
        end
        else
            in_taken <= 1'b0;
    end

    // result stall
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (res_taken)
                out_gap = out_stall_on ? $urandom_range(0, 15) : 0;
            if (out_gap > 0)
            begin
                out_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (next_gen_q.size() == 0)
            begin
                $error("result with nothing pending: row %0d col %0d",
                       m_axis_tdata[ROW_W:1], m_axis_tdata[ROW_W+COL_W:ROW_W+1]);
                err_count++;
            end
            else
            begin
                want_cell = next_gen_q.pop_front();
                check_field("next_alive", want_cell.next_alive, m_axis_tdata[0]);
                check_field("row_index", want_cell.row, m_axis_tdata[ROW_W:1]);
                check_field("col_index", want_cell.col, m_axis_tdata[ROW_W+COL_W:ROW_W+1]);
                check_field("frame_last", want_cell.last, m_axis_tlast);
            end
            res_taken <= 1'b1;
        end
        else
            res_taken <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("life_automaton_generation_core verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        int sel;
        int hv;
        int wv;
        int total;
        int span;
        int noise;
        int density;
        int phase_cnt;

        grid_h_reg = GRID_HEIGHT_RST;
        grid_w_reg = GRID_WIDTH_RST;
        foreach (line_top[k])
        begin
            line_top[k] = 1'b0;
            line_mid[k] = 1'b0;
        end
        window    = '0;
        frame_pos = 0;
        res_row   = 0;
        res_col   = 0;
        phase_cnt = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // blinker on 3x3: horizontal bar turns vertical
        write_grid_reg(CFG_GRID_HEIGHT, 8'd3);
        write_grid_reg(CFG_GRID_WIDTH, 8'd3);
        for (i = 0; i < 9; i++)
            push_req(CMD_CELL, i >= 3 && i <= 5);
        repeat (4) push_req(CMD_FLUSH, 1'b0);
        wait_drained();

        // zero sizes act as 1x1: lone live cell dies
        write_grid_reg(CFG_GRID_HEIGHT, 8'd0);
        write_grid_reg(CFG_GRID_WIDTH, 8'd0);
        push_req(CMD_CELL, 1'b1);
        push_req(CMD_FLUSH, 1'b1);
        push_req(CMD_FLUSH, 1'b0);
        wait_drained();

        // 2x2: flush inside the cells reads dead, cell in the tail acts as flush
        write_grid_reg(CFG_GRID_HEIGHT, 8'd2);
        write_grid_reg(CFG_GRID_WIDTH, 8'd2);
        push_req(CMD_CELL, 1'b1);
        push_req(CMD_FLUSH, 1'b1);
        push_req(CMD_CELL, 1'b1);
        push_req(CMD_CELL, 1'b1);
        push_req(CMD_CELL, 1'b1);
        push_req(CMD_FLUSH, 1'b0);
        push_req(CMD_CELL, 1'b0);
        wait_drained();

        while (items_queued < TARGET_ITEMS)
        begin
            sel = (phase_cnt == 0) ? 3 : $urandom_range(0, 14);
            case (sel)
                0:
                begin
                    hv = $urandom_range(1, 2);
                    case ($urandom_range(2))
                        0:       wv = 128;
                        1:       wv = 200;
                        default: wv = 255;
                    endcase
                end
                1:
                begin
                    case ($urandom_range(2))
                        0:       hv = 64;
                        1:       hv = 100;
                        default: hv = 255;
                    endcase
                    wv = $urandom_range(1, 2);
                end
                2:
                begin
                    hv = $urandom_range(1) ? 0 : $urandom_range(1, 4);
                    wv = (hv == 0) ? $urandom_range(0, 4) : 0;
                end
                3:
                begin
                    hv = 127;
                    wv = 255;
                end
                default:
                begin
                    hv = $urandom_range(1, 6);
                    wv = $urandom_range(1, 10);
                end
            endcase

            if (sel >= 4 && $urandom_range(3) == 0)
            begin
                // resize one dimension only, frame may be left mid-way
                if ($urandom_range(1))
                    write_grid_reg(CFG_GRID_HEIGHT, hv[CFG_W-1:0]);
                else
                    write_grid_reg(CFG_GRID_WIDTH, wv[CFG_W-1:0]);
            end
            else
            begin
                write_grid_reg(CFG_GRID_HEIGHT, hv[CFG_W-1:0]);
                write_grid_reg(CFG_GRID_WIDTH, wv[CFG_W-1:0]);
            end

            in_stall_on  = $urandom_range(1);
            out_stall_on = $urandom_range(1);

            gen_pos = frame_pos;
            total   = frame_items();
            if (gen_pos >= total)
                gen_pos = 0;
            if (total <= 150)
                span = (total - gen_pos) + $urandom_range(1) * total;
            else
                span = $urandom_range(100, 300);
            if ($urandom_range(9) == 0)
                span = $urandom_range(1, span);
            noise   = ($urandom_range(4) == 0) ? 10 : 0;
            density = $urandom_range(15, 65);
            queue_cells(span, noise, density);
            wait_drained();
            phase_cnt++;
        end

        if (err_count == 0)
            $display("life_automaton_generation_core verification clean");
        else
            $display("life_automaton_generation_core verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/lifegen_pkg.sv
hw/rtl/lifegen_ram.sv
hw/rtl/lifegen_front.sv
hw/rtl/lifegen_fifo.sv
hw/rtl/lifegen_back.sv
hw/rtl/life_automaton_generation_core.sv
sim/life_automaton_generation_core_test.sv
